[hdl/ctrp_pkg.sv]
// ----------------------------------------------------------------------------
// ctrp_pkg
// Types and constants shared by the transfer ring producer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ctrp_pkg;

  // Entry type codes, placed in control bits 15:10.
  typedef enum logic [5:0] {
    ENTRY_NORMAL = 6'd1,
    ENTRY_SETUP  = 6'd2,
    ENTRY_DATA   = 6'd3,
    ENTRY_STATUS = 6'd4,
    ENTRY_LINK   = 6'd6
  } trb_type_t;

  // Flags in control bits 9:0 (bit 0, the cycle bit, is added last).
  localparam logic [9:0] FLAG_TOGGLE = 10'h002;
  localparam logic [9:0] FLAG_CHAIN  = 10'h010;
  localparam logic [9:0] FLAG_IOC    = 10'h020;
  localparam logic [9:0] FLAG_IDT    = 10'h040;

  // Setup transfer type field (control bits 17:16).
  localparam logic [1:0] TRT_NO_DATA = 2'd0;
  localparam logic [1:0] TRT_OUT     = 2'd2;
  localparam logic [1:0] TRT_IN      = 2'd3;

  localparam logic [31:0] SETUP_LEN  = 32'd8;

  // Request opcodes.
  localparam logic OP_CONTROL = 1'b0;
  localparam logic OP_NORMAL  = 1'b1;

  // Queue between the classifier and the entry sequencer.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // APB register map.
  localparam logic REG_RING_BASE = 1'b0;

  // Classified request.
  typedef struct packed {
    logic        normal;
    logic        has_data;
    logic        dir_in;
    logic [63:0] setup;
    logic [15:0] len;
    logic [63:0] buf_addr;
  } cmd_t;

  // One ring entry as presented on the output.
  typedef struct packed {
    logic [63:0] param;
    logic [31:0] status;
    logic [31:0] control;
    logic [63:0] addr;
    logic        last;
  } trb_t;

  // Control word without the cycle bit.
  function automatic logic [31:0] make_control(trb_type_t kind, logic [1:0] hi,
                                               logic [9:0] flags);
    make_control = {14'd0, hi, kind, flags};
  endfunction

endpackage

`default_nettype wire

[hdl/ctrp_req_if.sv]
// ----------------------------------------------------------------------------
// ctrp_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctrp_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_index;
  logic [15:0] xfer_length;
  logic [63:0] buf_addr;

  modport source (output valid, op, request_type, request_code, request_value,
                  request_index, xfer_length, buf_addr, input ready);
  modport sink   (input valid, op, request_type, request_code, request_value,
                  request_index, xfer_length, buf_addr, output ready);
endinterface

`default_nettype wire

[hdl/ctrp_trb_if.sv]
// ----------------------------------------------------------------------------
// ctrp_trb_if
// Ring entry channel: valid/ready handshake with the entry fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctrp_trb_if;
  logic        valid;
  logic        ready;
  logic [63:0] trb_param;
  logic [31:0] trb_length;
  logic [31:0] trb_control;
  logic [63:0] trb_addr;
  logic        last;

  modport source (output valid, trb_param, trb_length, trb_control, trb_addr,
                  last, input ready);
  modport sink   (input valid, trb_param, trb_length, trb_control, trb_addr,
                  last, output ready);
endinterface

`default_nettype wire

[hdl/ctrp_front.sv]
// ----------------------------------------------------------------------------
// ctrp_front
// Accept requests and classify them into queue commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ctrp_front
  import ctrp_pkg::*;
(
  ctrp_req_if.sink req,
  input  wire logic q_full,
  output logic      push,
  output cmd_t      cmd
);

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  always_comb begin
    cmd.normal   = (req.op == OP_NORMAL);
    cmd.has_data = (req.xfer_length != 16'd0);
    cmd.dir_in   = req.request_type[7];
    // Pack the 8-byte setup packet, low byte first.
    cmd.setup    = {req.xfer_length, req.request_index, req.request_value,
                    req.request_code, req.request_type};
    cmd.len      = req.xfer_length;
    cmd.buf_addr = req.buf_addr;
  end

endmodule

`default_nettype wire

[hdl/ctrp_queue.sv]
// ----------------------------------------------------------------------------
// ctrp_queue
// Short command queue between classifier and entry sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ctrp_queue
  import ctrp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      wr_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head
);

  cmd_t                 mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_PTR_W:0]     count;

  assign full       = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/ctrp_back.sv]
// ----------------------------------------------------------------------------
// ctrp_back
// Entry sequencer: emit one ring entry a cycle when not stalled, insert link
// entries at the ring end, and hold the enqueue index and producer cycle bit.
// ----------------------------------------------------------------------------
`default_nettype none

module ctrp_back
  import ctrp_pkg::*;
#(
  parameter int RING_ENTRIES = 256
)(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [63:0] ring_base,
  input  wire logic        head_valid,
  input  cmd_t             head,
  output logic             pop,
  ctrp_trb_if.source       trb
);

  localparam int IDX_W = $clog2(RING_ENTRIES + 1);

  typedef enum logic [2:0] {
    STEP_SETUP  = 3'b001,
    STEP_DATA   = 3'b010,
    STEP_STATUS = 3'b100
  } step_t;

  logic [IDX_W-1:0] enq_index, enq_index_next;
  logic             pcycle, pcycle_next;
  step_t            step, step_next;
  trb_t             entry, out_reg;
  logic             out_valid;
  logic             load, advance, wrap;
  logic [63:0]      base_al;
  logic [31:0]      ctl;

  assign load    = !out_valid || trb.ready;
  assign advance = head_valid && load;
  assign wrap    = (enq_index == IDX_W'(RING_ENTRIES));
  assign base_al = {ring_base[63:4], 4'd0};

  always_comb begin
    ctl         = '0;
    entry.param = '0;
    entry.status = '0;
    entry.last  = 1'b0;
    entry.addr  = base_al + {{(60-IDX_W){1'b0}}, enq_index, 4'd0};
    if (wrap) begin
      ctl         = make_control(ENTRY_LINK, 2'd0, FLAG_TOGGLE);
      entry.param = base_al;
    end else if (head.normal) begin
      ctl          = make_control(ENTRY_NORMAL, 2'd0, FLAG_IOC);
      entry.param  = head.buf_addr;
      entry.status = {16'd0, head.len};
      entry.last   = 1'b1;
    end else begin
      unique case (step)
        STEP_SETUP: begin
          ctl = make_control(ENTRY_SETUP,
                             !head.has_data ? TRT_NO_DATA :
                             (head.dir_in ? TRT_IN : TRT_OUT),
                             FLAG_IDT | FLAG_CHAIN);
          entry.param  = head.setup;
          entry.status = SETUP_LEN;
        end
        STEP_DATA: begin
          ctl          = make_control(ENTRY_DATA, {1'b0, head.dir_in}, FLAG_CHAIN);
          entry.param  = head.buf_addr;
          entry.status = {16'd0, head.len};
        end
        default: begin
          ctl = make_control(ENTRY_STATUS, {1'b0, !(head.has_data && head.dir_in)},
                             FLAG_IOC);
          entry.last = 1'b1;
        end
      endcase
    end
    entry.control = {ctl[31:1], pcycle};
  end

  // Sequencer next state.
  always_comb begin
    enq_index_next = enq_index;
    pcycle_next    = pcycle;
    step_next      = step;
    pop            = 1'b0;
    if (advance) begin
      if (wrap) begin
        enq_index_next = '0;
        pcycle_next    = !pcycle;
      end else begin
        enq_index_next = enq_index + 1'b1;
        if (entry.last) begin
          pop       = 1'b1;
          step_next = STEP_SETUP;
        end else if (step == STEP_SETUP && head.has_data) begin
          step_next = STEP_DATA;
        end else begin
          step_next = STEP_STATUS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enq_index <= '0;
      pcycle    <= 1'b1;
      step      <= STEP_SETUP;
      out_valid <= 1'b0;
    end else begin
      enq_index <= enq_index_next;
      pcycle    <= pcycle_next;
      step      <= step_next;
      if (load) begin
        out_valid <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= entry;
    end
  end

  assign trb.valid       = out_valid;
  assign trb.trb_param   = out_reg.param;
  assign trb.trb_length  = out_reg.status;
  assign trb.trb_control = out_reg.control;
  assign trb.trb_addr    = out_reg.addr;
  assign trb.last        = out_reg.last;

endmodule

`default_nettype wire

[hdl/control_transfer_trb_producer.sv]
// The first entry of a request is registered in the queue and then in the
//   output register before it is offered on the entry channel.
// Throughput: one ring entry per cycle unless stalled; a control request
//   yields setup, optional data and status entries, a normal request one.
// Requests queue up to 4 deep, so input is taken while entries drain.
// Reset (synchronous, rst high): index 0, cycle bit 1, ring base 0, queue empty.
// ----------------------------------------------------------------------------
// control_transfer_trb_producer
// Transfer ring producer: turns control and normal requests into ring
// entries, wrapping through a link entry at the ring end.
// ----------------------------------------------------------------------------
`default_nettype none

module control_transfer_trb_producer
  import ctrp_pkg::*;
#(
  parameter int RING_ENTRIES = 256
)(
  input  wire logic        clk,
  input  wire logic        rst,
  // APB register port: one 64-bit register at byte address 0.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  ctrp_req_if.sink         req,
  ctrp_trb_if.source       trb
);

  logic [63:0] ring_base;
  logic        push, pop, q_full, head_valid;
  cmd_t        wr_cmd, head;

  // Register file: the write lands on the access cycle; addresses with
  // paddr[3] set are dropped.
  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_RING_BASE) ? ring_base : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_base <= '0;
    end else if (psel && penable && pwrite && paddr[3] == REG_RING_BASE) begin
      ring_base <= pwdata;
    end
  end

  // Front: accept and classify each request.
  ctrp_front u_front (
    .req    (req),
    .q_full (q_full),
    .push   (push),
    .cmd    (wr_cmd)
  );

  // Queue: decouple request intake from entry generation.
  ctrp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_cmd     (wr_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: sequence entries, insert links, own index and cycle bit.
  ctrp_back #(
    .RING_ENTRIES (RING_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .ring_base  (ring_base),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .trb        (trb)
  );

  // A link entry never closes a request.
  a_link_not_last: assert property (@(posedge clk) disable iff (rst)
    (trb.valid && trb.last) |-> trb.trb_control[15:10] != ENTRY_LINK)
    else $error("link entry flagged as last");

  // Every entry lands on a 16-byte boundary.
  a_addr_aligned: assert property (@(posedge clk) disable iff (rst)
    trb.valid |-> trb.trb_addr[3:0] == 4'd0)
    else $error("unaligned entry address");

  // A request is popped only when the queue holds one.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  // No entry is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !trb.valid)
    else $error("entry valid after reset");

endmodule

`default_nettype wire

[bench/ctrp_ring_checker.sv]
// ----------------------------------------------------------------------------
// ctrp_ring_checker
// Watches the register port and both channels of the transfer ring producer,
// works out the ring entries of every accepted request and compares them, in
// order, with the entries that the block hands out.
// ----------------------------------------------------------------------------
module ctrp_ring_checker
  import ctrp_pkg::*;
#(
  parameter int RING_ENTRIES = 256
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic [63:0] prdata,
  input  logic        pready,
  ctrp_req_if         req,
  ctrp_trb_if         trb,
  output int unsigned failures,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] RING_BASE_ADDR = {REG_RING_BASE, 3'b000};
  localparam int SLOT_W = $clog2(RING_ENTRIES + 1);

  logic [63:0]       ring_base;
  logic [SLOT_W-1:0] enq_slot;
  logic              prod_cycle;
  trb_t              ring_writes[$];

  function automatic logic [31:0] control_word(trb_type_t kind, logic [1:0] hi,
                                               logic [9:0] flags);
    return (32'(hi) << 16) | (32'(kind) << 10) | 32'(flags);
  endfunction

  // Low four bits of the base are dropped: entries are 16 bytes.
  function automatic logic [63:0] ring_origin();
    return {ring_base[63:4], 4'h0};
  endfunction

  // Queue one entry, inserting the link entry first when the ring is full.
  function automatic void write_slot(logic [63:0] param, logic [31:0] status,
                                     logic [31:0] control, logic last);
    trb_t e;
    if (int'(enq_slot) >= RING_ENTRIES) begin
      e.param   = ring_origin();
      e.status  = '0;
      e.control = control_word(ENTRY_LINK, 2'b00, FLAG_TOGGLE) | 32'(prod_cycle);
      e.addr    = ring_origin() + 64'(RING_ENTRIES) * 64'd16;
      e.last    = 1'b0;
      ring_writes.push_back(e);
      enq_slot   = '0;
      prod_cycle = ~prod_cycle;
    end
    e.param   = param;
    e.status  = status;
    e.control = {control[31:1], prod_cycle};
    e.addr    = ring_origin() + 64'(enq_slot) * 64'd16;
    e.last    = last;
    ring_writes.push_back(e);
    enq_slot = enq_slot + 1'b1;
  endfunction

  function automatic void predict_request();
    logic        dir_in;
    logic [15:0] len;
    logic [1:0]  trt;
    dir_in = req.request_type[7];
    len    = req.xfer_length;
    if (req.op == OP_NORMAL) begin
      write_slot(req.buf_addr, 32'(len), control_word(ENTRY_NORMAL, 2'b00, FLAG_IOC), 1'b1);
    end else begin
      if (len == 16'd0) trt = TRT_NO_DATA;
      else trt = dir_in ? TRT_IN : TRT_OUT;
      write_slot({len, req.request_index, req.request_value, req.request_code,
                  req.request_type},
                 SETUP_LEN, control_word(ENTRY_SETUP, trt, FLAG_IDT | FLAG_CHAIN), 1'b0);
      if (len != 16'd0) begin
        write_slot(req.buf_addr, 32'(len),
                   control_word(ENTRY_DATA, {1'b0, dir_in}, FLAG_CHAIN), 1'b0);
        write_slot('0, '0, control_word(ENTRY_STATUS, {1'b0, ~dir_in}, FLAG_IOC), 1'b1);
      end else begin
        write_slot('0, '0, control_word(ENTRY_STATUS, 2'b01, FLAG_IOC), 1'b1);
      end
    end
  endfunction

  function automatic void report_entry(string what, trb_t want, trb_t got);
    failures++;
    if (failures <= 10) begin
      $display("%0t: %s", $time, what);
      $display("  expected param %h status %h control %h addr %h last %b",
               want.param, want.status, want.control, want.addr, want.last);
      $display("  actual   param %h status %h control %h addr %h last %b",
               got.param, got.status, got.control, got.addr, got.last);
    end
  endfunction

  initial begin
    failures = 0;
    pending  = 0;
  end

  always @(posedge clk) begin
    trb_t got;
    trb_t want;
    if (rst) begin
      ring_base  = '0;
      enq_slot   = '0;
      prod_cycle = 1'b1;
      ring_writes.delete();
    end else begin
      // Track register writes; check reads of the ring base.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == RING_BASE_ADDR) ring_base = pwdata;
        end else if (paddr == RING_BASE_ADDR && prdata !== ring_base) begin
          failures++;
          if (failures <= 10)
            $display("%0t: ring base read back: expected %h, actual %h",
                     $time, ring_base, prdata);
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) predict_request();
      if (trb.valid === 1'b1 && trb.ready === 1'b1) begin
        got = '{trb.trb_param, trb.trb_length, trb.trb_control, trb.trb_addr, trb.last};
        if (ring_writes.size() == 0) begin
          want = '0;
          report_entry("ring entry with nothing expected", want, got);
        end else begin
          want = ring_writes.pop_front();
          if (got.param !== want.param || got.status !== want.status ||
              got.control !== want.control || got.addr !== want.addr ||
              got.last !== want.last)
            report_entry("ring entry mismatch", want, got);
        end
      end
    end
    pending = ring_writes.size();
  end

endmodule

[bench/control_transfer_trb_producer_test.sv]
// ----------------------------------------------------------------------------
// control_transfer_trb_producer_test
// Drives control and normal requests into the transfer ring producer across
// several ring base settings, with random idling on both channels, and lets
// the ring checker compare every ring entry against its own prediction.
// ----------------------------------------------------------------------------
module control_transfer_trb_producer_test
  import ctrp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] RING_BASE_ADDR = {REG_RING_BASE, 3'b000};
  // Next register slot: nothing lives there, so writes must be dropped.
  localparam logic [3:0] SPARE_ADDR = 4'h8;
  // Long enough for the request queue to fill and stall the input.
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic        op;
    logic [7:0]  request_type;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] windex;
    logic [15:0] length;
    logic [63:0] buf_addr;
  } request_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  int unsigned failures;
  int unsigned pending;

  // Idling knobs, percent chance per transaction of starting a burst.
  int unsigned gap_pct;
  int unsigned stall_pct;
  bit          hold_request;

  ctrp_req_if req ();
  ctrp_trb_if trb ();

  control_transfer_trb_producer uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req),
    .trb     (trb)
  );

  ctrp_ring_checker ring_check (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .req      (req),
    .trb      (trb),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  // Ring entry side: random stall bursts, plus one long hold-off on
  // request, counted here cycle by cycle.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    trb.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        trb.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        trb.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 9);
        trb.ready <= 1'b0;
      end else begin
        trb.ready <= 1'b1;
      end
    end
  end

  // One register transaction: setup cycle, then access cycle until pready.
  // Drop psel and wait idle before returning, so that psel drops and rises on separate edges.
  task automatic reg_access(input logic is_write, input logic [3:0] addr,
                            input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Write the ring base and read it back.
  task automatic set_ring_base(input logic [63:0] base);
    reg_access(1'b1, RING_BASE_ADDR, base);
    reg_access(1'b0, RING_BASE_ADDR, '0);
  endtask

  // Offer one request and hold it until the block takes the transaction;
  // maybe drop valid for a short gap afterwards.
  task automatic send_request(input request_t r);
    req.valid         <= 1'b1;
    req.op            <= r.op;
    req.request_type  <= r.request_type;
    req.request_code  <= r.code;
    req.request_value <= r.value;
    req.request_index <= r.windex;
    req.xfer_length   <= r.length;
    req.buf_addr      <= r.buf_addr;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every predicted entry has come out.
  task automatic drain_ring();
    req.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  function automatic request_t make_request(logic op, logic [7:0] bmr, logic [7:0] code,
                                            logic [15:0] value, logic [15:0] windex,
                                            logic [15:0] length, logic [63:0] buf_addr);
    request_t r;
    r.op           = op;
    r.request_type = bmr;
    r.code         = code;
    r.value        = value;
    r.windex       = windex;
    r.length       = length;
    r.buf_addr     = buf_addr;
    return r;
  endfunction

  // A mix of short and random data stages, a fair share of zero and full lengths.
  function automatic request_t random_request();
    request_t r;
    r.op           = $urandom_range(0, 1) ? OP_NORMAL : OP_CONTROL;
    r.request_type = 8'($urandom);
    r.code         = 8'($urandom);
    r.value        = 16'($urandom);
    r.windex       = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1:    r.length = 16'd0;
      2:       r.length = 16'hFFFF;
      3, 4, 5: r.length = 16'($urandom_range(1, 64));
      default: r.length = 16'($urandom);
    endcase
    r.buf_addr = {$urandom, $urandom};
    return r;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_request(random_request());
  endtask

  initial begin
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req.valid         = 1'b0;
    req.op            = OP_CONTROL;
    req.request_type  = '0;
    req.request_code  = '0;
    req.request_value = '0;
    req.request_index = '0;
    req.xfer_length   = '0;
    req.buf_addr      = '0;
    gap_pct           = 30;
    stall_pct         = 30;
    hold_request      = 1'b0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part on the reset base: read it back first.
    reg_access(1'b0, RING_BASE_ADDR, '0);
    // Control without data, out and in request types.
    send_request(make_request(OP_CONTROL, 8'h00, 8'h05, 16'h0012, 16'h0000, 16'd0, '0));
    send_request(make_request(OP_CONTROL, 8'h80, 8'h00, 16'h0000, 16'h0000, 16'd0, '0));
    // Control with in data and with out data.
    send_request(make_request(OP_CONTROL, 8'h80, 8'h06, 16'h0100, 16'h0000, 16'd64,
                              64'h0000_0000_1000_0000));
    send_request(make_request(OP_CONTROL, 8'h00, 8'h09, 16'h0001, 16'h0000, 16'd8,
                              64'h0000_0001_0000_0040));
    // Every field at its top, then low fields (request type 7F) with a one-byte stage.
    send_request(make_request(OP_CONTROL, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              64'hFFFF_FFFF_FFFF_FFFF));
    send_request(make_request(OP_CONTROL, 8'h7F, 8'h00, 16'h0000, 16'h0000, 16'd1, '0));
    // Normal: zero length, full length, ordinary.
    send_request(make_request(OP_NORMAL, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'd0, '0));
    send_request(make_request(OP_NORMAL, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              64'hFFFF_FFFF_FFFF_FFFF));
    send_request(make_request(OP_NORMAL, 8'h80, 8'h01, 16'h0000, 16'h0000, 16'h1234,
                              64'hA5A5_A5A5_5A5A_5A5A));
    send_request(make_request(OP_CONTROL, 8'h21, 8'h09, 16'h0200, 16'h0001, 16'd0, '0));
    send_request(make_request(OP_CONTROL, 8'h80, 8'h06, 16'h0100, 16'h0000, 16'd18,
                              64'h0000_0000_0002_0000));
    send_request(make_request(OP_NORMAL, 8'hFF, 8'h00, 16'h0000, 16'h0000, 16'd1,
                              64'h8000_0000_0000_0001));
    // Alternating bit patterns through every field.
    send_request(make_request(OP_CONTROL, 8'hAA, 8'h55, 16'hAAAA, 16'h5555, 16'h5555,
                              64'h5555_5555_5555_5555));
    send_request(make_request(OP_CONTROL, 8'h55, 8'hAA, 16'h5555, 16'hAAAA, 16'hAAAA,
                              64'hAAAA_AAAA_AAAA_AAAA));
    send_request(make_request(OP_NORMAL, 8'hAA, 8'h55, 16'hAAAA, 16'h5555, 16'hAAAA,
                              64'hAAAA_AAAA_AAAA_AAAA));
    send_request(make_request(OP_NORMAL, 8'h55, 8'hAA, 16'h5555, 16'hAAAA, 16'h5555,
                              64'h5555_5555_5555_5555));

    // All-ones base: unaligned, and entry addresses wrap past 2^64.
    // Write the empty slot too; the base must survive it. No idling here.
    drain_ring();
    set_ring_base(64'hFFFF_FFFF_FFFF_FFFF);
    reg_access(1'b1, SPARE_ADDR, 64'h0123_4567_89AB_CDEF);
    reg_access(1'b0, RING_BASE_ADDR, '0);
    gap_pct   = 0;
    stall_pct = 0;
    run_random(24);

    // Random base; hold the entry side off long enough to back up requests.
    drain_ring();
    set_ring_base({$urandom, $urandom});
    gap_pct      = 10;
    stall_pct    = 20;
    hold_request = 1'b1;
    run_random(60);

    // Base near the top of the address space, heavy idling, with one full
    // pause mid-phase until the ring drains.
    drain_ring();
    set_ring_base(64'hFFFF_FFFF_FFFF_F808);
    gap_pct   = 40;
    stall_pct = 40;
    run_random(30);
    drain_ring();
    run_random(30);

    // Back to base zero and run flat out to the end.
    drain_ring();
    set_ring_base(64'h0);
    gap_pct   = 0;
    stall_pct = 0;
    run_random(48);

    drain_ring();
    // Let any stray entry surface before the verdict.
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/ctrp_pkg.sv
hdl/ctrp_req_if.sv
hdl/ctrp_trb_if.sv
hdl/ctrp_front.sv
hdl/ctrp_queue.sv
hdl/ctrp_back.sv
hdl/control_transfer_trb_producer.sv
bench/ctrp_ring_checker.sv
bench/control_transfer_trb_producer_test.sv
